[sv/pdots_pkg.sv]
// Package: shared types and codes for the PDO transmit scheduler.
package pdots_pkg;

    // Number of setup registers on the configuration port
    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = 2;
    localparam int SETUP_W   = 44;
    localparam int IDENT_W   = 11;
    localparam int FIELD_W   = 16;

    // Input function codes
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_NOTIFY = 1'b1;

    // Packed setup register layout, MSB first
    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic               enable;
        logic [FIELD_W-1:0] event_reload;
        logic [FIELD_W-1:0] inhibit_reload;
    } setup_t;

endpackage

[sv/pdots_in_if.sv]
// Interface: input beat channel (tick or change-of-state notify).
interface pdots_in_if;
    import pdots_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [SLOT_W-1:0] object_index;

    modport source (output valid, output func, output object_index, input ready);
    modport sink   (input valid, input func, input object_index, output ready);
endinterface

[sv/pdots_out_if.sv]
// Interface: output beat channel carrying one due transmission.
interface pdots_out_if;
    import pdots_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  sent_index;
    logic [IDENT_W-1:0] sent_ident;
    logic               last;

    modport source (output valid, output sent_index, output sent_ident, output last,
                    input ready);
    modport sink   (input valid, input sent_index, input sent_ident, input last,
                    output ready);
endinterface

[sv/pdots_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pdots_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/pdots_engine.sv]
// Scan engine: read-modify-write of per-object counters and beat output stage.
module pdots_engine
    import pdots_pkg::*;
#(
    parameter int NUM_OBJECTS = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    pdots_in_if.sink          in_ch,
    pdots_out_if.source       out_ch,
    output logic [SLOT_W-1:0] obj_index,
    input  setup_t            obj_setup
);

    localparam int AW     = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int WORD_W = 2 * COUNT_WIDTH + 1;
    localparam logic [SLOT_W-1:0] LAST_OBJ = SLOT_W'(NUM_OBJECTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FLUSH
    } state_t;

    state_t             state_reg, state_next;
    logic               notify_reg, notify_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [NUM_OBJECTS-1:0] entry_valid_reg, entry_valid_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]  pend_index_reg, pend_index_next;
    logic [IDENT_W-1:0] pend_ident_reg, pend_ident_next;

    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_index_reg, out_index_next;
    logic [IDENT_W-1:0] out_ident_reg, out_ident_next;
    logic               out_last_reg, out_last_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_W-1:0]      ram_wdata, ram_rdata, entry;
    logic [COUNT_WIDTH-1:0] cur_inh, cur_evt, new_inh, new_evt;
    logic                   cur_flag, new_flag;
    logic                   due, emit, out_free, proceed;

    pdots_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_OBJECTS),
        .ADDR_W(AW)
    ) u_state_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cur_reg[AW-1:0]),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Entries never written read as zero
    assign entry    = entry_valid_reg[cur_reg[AW-1:0]] ? ram_rdata : '0;
    assign cur_flag = entry[WORD_W-1];
    assign cur_evt  = entry[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign cur_inh  = entry[COUNT_WIDTH-1:0];

    assign obj_index = cur_reg;
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Per-object tick update
    always_comb
    begin
        new_inh  = cur_inh;
        new_evt  = cur_evt;
        new_flag = cur_flag;
        due      = 1'b0;
        if (cur_inh != '0)
        begin
            new_inh = cur_inh - 1'b1;
        end
        else if (cur_evt != '0 && !cur_flag)
        begin
            new_evt = cur_evt - 1'b1;
        end
        else
        begin
            new_inh  = COUNT_WIDTH'(obj_setup.inhibit_reload);
            new_evt  = COUNT_WIDTH'(obj_setup.event_reload);
            new_flag = 1'b0;
            due      = 1'b1;
        end
    end

    assign emit    = due && obj_setup.enable;
    // Hold the scan when a new beat would displace a pending one that cannot leave
    assign proceed = !(emit && pend_valid_reg && !out_free);

    always_comb
    begin
        state_next       = state_reg;
        notify_next      = notify_reg;
        cur_next         = cur_reg;
        entry_valid_next = entry_valid_reg;
        pend_valid_next  = pend_valid_reg;
        pend_index_next  = pend_index_reg;
        pend_ident_next  = pend_ident_reg;
        out_valid_next   = out_valid_reg;
        out_index_next   = out_index_reg;
        out_ident_next   = out_ident_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = cur_reg[AW-1:0];
        ram_wdata        = {new_flag, new_evt, new_inh};
        in_ch.ready      = (state_reg == S_IDLE);

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.func == FUNC_NOTIFY)
                    begin
                        // Drop notifies to absent objects
                        if (int'(in_ch.object_index) < NUM_OBJECTS)
                        begin
                            cur_next    = in_ch.object_index;
                            ram_re      = 1'b1;
                            ram_raddr   = in_ch.object_index[AW-1:0];
                            notify_next = 1'b1;
                            state_next  = S_EVAL;
                        end
                    end
                    else
                    begin
                        cur_next    = '0;
                        ram_re      = 1'b1;
                        ram_raddr   = '0;
                        notify_next = 1'b0;
                        state_next  = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (notify_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, cur_evt, cur_inh};
                    entry_valid_next[cur_reg[AW-1:0]] = 1'b1;
                    state_next = S_IDLE;
                end
                else if (proceed)
                begin
                    ram_we = 1'b1;
                    entry_valid_next[cur_reg[AW-1:0]] = 1'b1;
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_index_next = pend_index_reg;
                            out_ident_next = pend_ident_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_index_next = cur_reg;
                        pend_ident_next = obj_setup.ident;
                    end
                    if (cur_reg == LAST_OBJ)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cur_next  = cur_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = cur_next[AW-1:0];
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = pend_index_reg;
                    out_ident_next  = pend_ident_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            notify_reg      <= 1'b0;
            cur_reg         <= '0;
            entry_valid_reg <= '0;
            pend_valid_reg  <= 1'b0;
            pend_index_reg  <= '0;
            pend_ident_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_index_reg   <= '0;
            out_ident_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            notify_reg      <= notify_next;
            cur_reg         <= cur_next;
            entry_valid_reg <= entry_valid_next;
            pend_valid_reg  <= pend_valid_next;
            pend_index_reg  <= pend_index_next;
            pend_ident_reg  <= pend_ident_next;
            out_valid_reg   <= out_valid_next;
            out_index_reg   <= out_index_next;
            out_ident_reg   <= out_ident_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sent_index = out_index_reg;
    assign out_ch.sent_ident = out_ident_reg;
    assign out_ch.last       = out_last_reg;

endmodule

[sv/pdo_transmit_scheduler.sv]
// Top level: PDO transmit scheduler with setup registers and scan engine.
//
//   channel  | dir | beat contents                          | handshake
//   ---------+-----+----------------------------------------+------------------
//   in_ch    | in  | func, object_index                     | valid/ready
//   out_ch   | out | sent_index, sent_ident, last           | valid/ready
//   cfg      | in  | cfg_index, cfg_data (44-bit setup)     | cfg_we, no wait
//
// A tick is accepted only while idle; the acceptance cycle issues the first
// state-RAM read, then one object per cycle, while the scan is not held, goes
// through the shared decrement/reload path, then a release step passes the held
// final beat to the output. A notify reads, then writes back with the flag set.
// Reset clears the setup registers and the per-entry valid bits; a state
// entry that was never written reads as zero, so no clearing pass is run.
// A stalled output halts the scan when a second due beat is found while the
// output register and the hold slot are both occupied, and holds the release
// cycle while the final beat cannot enter the output register.
module pdo_transmit_scheduler
    import pdots_pkg::*;
#(
    parameter int NUM_OBJECTS = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    pdots_in_if.sink           in_ch,
    pdots_out_if.source        out_ch,
    input  logic               cfg_we,
    input  logic [SLOT_W-1:0]  cfg_index,
    input  logic [SETUP_W-1:0] cfg_data
);

    // One packed setup register per slot; slots beyond NUM_OBJECTS are stored
    // but never read by the scan.
    logic [SETUP_W-1:0] setup_reg [NUM_SLOTS];
    logic [SLOT_W-1:0]  obj_index;
    setup_t             obj_setup;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                setup_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            setup_reg[cfg_index] <= cfg_data;
        end
    end

    // Decode the setup of the object under evaluation
    assign obj_setup = setup_t'(setup_reg[obj_index]);

    pdots_engine #(
        .NUM_OBJECTS(NUM_OBJECTS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .obj_index(obj_index),
        .obj_setup(obj_setup)
    );

endmodule
